### rtl/ordered_key_value_table_assert.svh
// Assertion helpers for the ordered key/value table.
// Each check is sampled on the rising clock and is off while reset is low.
`ifndef ORDERED_KEY_VALUE_TABLE_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_ASSERT_SVH

// Property that holds on every clock edge.
`define OKVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a property in the next.
`define OKVT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);

`endif

### rtl/okvt_pkg.sv
`default_nettype none
package okvt_pkg;

	localparam logic [2:0] KIND_INSERT   = 3'd0;
	localparam logic [2:0] KIND_UPDATE   = 3'd1;
	localparam logic [2:0] KIND_UPSERT   = 3'd2;
	localparam logic [2:0] KIND_ERASE    = 3'd3;
	localparam logic [2:0] KIND_LOOKUP   = 3'd4;
	localparam logic [2:0] KIND_READ_POS = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] key;
		logic [31:0] value;
		logic [5:0]  position;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] out_key;
		logic [31:0] out_value;
		logic [6:0]  entry_count;
	} out_item_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp;
		logic rd_pos;
		logic append;
		logic update;
		logic erase;
	} okvt_cmd_t;

	// per-cell compare result, registered in the compare cycle
	typedef struct packed {
		logic match;
		logic pick;
	} okvt_stat_t;

endpackage
`default_nettype wire

### rtl/okvt_cell.sv
`default_nettype none
module okvt_cell #(
	parameter int INDEX      = 0,
	parameter int IDX_W      = 6,
	parameter int CNT_W      = 7,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire                    clk,
	input  okvt_pkg::okvt_cmd_t    cmd,
	input  wire [KEY_BITS-1:0]     op_key,
	input  wire [VALUE_BITS-1:0]   op_value,
	input  wire [5:0]              op_pos,
	input  wire [CNT_W-1:0]        count,
	input  wire [IDX_W-1:0]        hit_idx,
	input  wire [KEY_BITS-1:0]     next_key,
	input  wire [VALUE_BITS-1:0]   next_value,
	output logic [KEY_BITS-1:0]    key,
	output logic [VALUE_BITS-1:0]  value,
	output okvt_pkg::okvt_stat_t   stat
);
	import okvt_pkg::*;

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	okvt_stat_t            stat_s2;
	okvt_stat_t            stat_d;
	logic                  live;
	logic                  pos_hit;

	always_comb begin
		live         = CNT_W'(INDEX) < count;
		pos_hit      = live && (32'(op_pos) == 32'(INDEX));
		stat_d.match = live && (key_q == op_key);
		stat_d.pick  = cmd.rd_pos ? pos_hit : stat_d.match;
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			stat_s2 <= stat_d;
		end
	end

	// erase: every cell at or above the hit takes its upper neighbor
	always_ff @(posedge clk) begin
		if (cmd.erase && (IDX_W'(INDEX) >= hit_idx)) begin
			key_q   <= next_key;
			value_q <= next_value;
		end else if (cmd.append && (CNT_W'(INDEX) == count)) begin
			key_q   <= op_key;
			value_q <= op_value;
		end else if (cmd.update && stat_s2.match) begin
			value_q <= op_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign stat  = stat_s2;

endmodule
`default_nettype wire

### rtl/ordered_key_value_table.sv
// Ordered key/value table: a row of CAPACITY cells, entries kept in insertion order.
// Request channel req_valid/req_ready/req_item carries kind, key, value, position.
// Response channel rsp_valid/rsp_ready/rsp_item returns ok, out_key, out_value and
// the entry count after the operation; one response per request, in order.
// An accepted request passes through compare (every cell checks its key and
// position against the request and registers the result) and then execute
// (results are combined, the row is written, the response register is loaded).
// A new request is not taken while one is in compare, since the registered compare
// lies ahead of the write; it is taken as the previous one leaves execute.
// Erase shifts every entry above the hit one cell down together, in execute.
// Reset empties the table at once (count cleared); cell contents are not cleared
// and no clearing pass runs. Entries at or above the count never match or return.
// When the receiver stalls, one finished response waits in the output register
// and a further request still enters compare; it holds in execute until the
// waiting response is taken.
`default_nettype none
`include "ordered_key_value_table_assert.svh"
module ordered_key_value_table #(
	parameter int CAPACITY   = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  okvt_pkg::in_item_t   req_item,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output okvt_pkg::out_item_t  rsp_item
);
	import okvt_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		IDLE,
		CMP,
		EXEC
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;

	logic [2:0]            kind_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [5:0]            pos_s1;

	logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
	logic [VALUE_BITS-1:0] cell_value [CAPACITY];
	okvt_stat_t            cell_stat  [CAPACITY];
	logic [CAPACITY-1:0]   match_vec;

	okvt_cmd_t             cmd;
	logic                  req_xfer;
	logic                  exec_go;
	logic                  hit;
	logic                  picked;
	logic                  room;
	logic [IDX_W-1:0]      hit_idx;
	logic [KEY_BITS-1:0]   pick_key;
	logic [VALUE_BITS-1:0] pick_value;
	logic                  ok_d;
	logic                  do_append;
	logic                  do_update;
	logic                  do_erase;
	logic [KEY_BITS-1:0]   out_key_d;
	logic [VALUE_BITS-1:0] out_value_d;
	logic [CNT_W-1:0]      count_d;

	assign exec_go   = (state_q == EXEC) && (!rsp_valid || rsp_ready);
	assign req_ready = (state_q == IDLE) || exec_go;
	assign req_xfer  = req_valid && req_ready;
	assign room      = count_q < CNT_W'(CAPACITY);

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			kind_s1  <= req_item.kind;
			key_s1   <= KEY_BITS'(req_item.key);
			value_s1 <= VALUE_BITS'(req_item.value);
			pos_s1   <= req_item.position;
		end
	end

	// combine the registered compare results of the row
	always_comb begin
		hit        = 1'b0;
		picked     = 1'b0;
		hit_idx    = '0;
		pick_key   = '0;
		pick_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit        = hit | cell_stat[i].match;
			picked     = picked | cell_stat[i].pick;
			hit_idx    = hit_idx | (cell_stat[i].match ? IDX_W'(i) : '0);
			pick_key   = pick_key | (cell_stat[i].pick ? cell_key[i] : '0);
			pick_value = pick_value | (cell_stat[i].pick ? cell_value[i] : '0);
		end
	end

	always_comb begin
		ok_d        = 1'b0;
		do_append   = 1'b0;
		do_update   = 1'b0;
		do_erase    = 1'b0;
		out_key_d   = '0;
		out_value_d = '0;
		unique case (kind_s1)
			KIND_INSERT: begin
				do_append = !hit && room;
				ok_d      = do_append;
			end
			KIND_UPDATE: begin
				do_update = hit;
				ok_d      = hit;
			end
			KIND_UPSERT: begin
				do_update = hit;
				do_append = !hit && room;
				ok_d      = do_update || do_append;
			end
			KIND_ERASE: begin
				do_erase = hit;
				ok_d     = hit;
			end
			KIND_LOOKUP: begin
				ok_d        = hit;
				out_value_d = pick_value;
			end
			KIND_READ_POS: begin
				ok_d        = picked;
				out_key_d   = pick_key;
				out_value_d = pick_value;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (do_append) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_erase) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		cmd.cmp    = (state_q == CMP);
		cmd.rd_pos = (kind_s1 == KIND_READ_POS);
		cmd.append = exec_go && do_append;
		cmd.update = exec_go && do_update;
		cmd.erase  = exec_go && do_erase;
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam int NXT = (g == CAPACITY - 1) ? g : g + 1;

		okvt_cell #(
			.INDEX      (g),
			.IDX_W      (IDX_W),
			.CNT_W      (CNT_W),
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.op_key     (key_s1),
			.op_value   (value_s1),
			.op_pos     (pos_s1),
			.count      (count_q),
			.hit_idx    (hit_idx),
			.next_key   (cell_key[NXT]),
			.next_value (cell_value[NXT]),
			.key        (cell_key[g]),
			.value      (cell_value[g]),
			.stat       (cell_stat[g])
		);

		assign match_vec[g] = cell_stat[g].match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			count_q   <= '0;
			rsp_valid <= 1'b0;
			rsp_item  <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (req_xfer) begin
						state_q <= CMP;
					end
				end
				CMP: begin
					state_q <= EXEC;
				end
				EXEC: begin
					if (exec_go) begin
						state_q <= req_xfer ? CMP : IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase

			if (exec_go) begin
				count_q               <= count_d;
				rsp_valid             <= 1'b1;
				rsp_item.ok           <= ok_d;
				rsp_item.out_key      <= 32'(out_key_d);
				rsp_item.out_value    <= 32'(out_value_d);
				rsp_item.entry_count  <= 7'(count_d);
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	`OKVT_ASSERT(a_unique_hit, (state_q == EXEC) |-> $onehot0(match_vec), "more than one cell matched the key")
	`OKVT_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`OKVT_ASSERT_NEXT(a_count_hold, !exec_go, $stable(count_q), "entry count moved outside execute")
	`OKVT_ASSERT(a_rsp_from_exec, $rose(rsp_valid) |-> ($past(state_q) == EXEC), "response raised outside execute")

endmodule
`default_nettype wire
